/* rtl/round_robin_process_scheduler_defines.svh */
// assertion macros for the round robin process scheduler
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// concurrent check, disabled while reset is asserted
`define RRPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rrps assertion failed");

// concurrent check that also holds during reset
`define RRPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rrps assertion failed");

`else

`define RRPS_ASSERT(lbl, clk, rst_n, prop)

`define RRPS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/rrps_pkg.sv */
// shared types and constants of the round robin process scheduler
package rrps_pkg;

  // operation codes of an input transaction
  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY       = 2'd2;

  // scheduling policies
  localparam logic POLICY_RR   = 1'b0;
  localparam logic POLICY_FCFS = 1'b1;

  // input transaction payload
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  entry;
    logic [15:0] burst;
  } in_item_t;

  // output transaction payload
  typedef struct packed {
    logic [3:0]  served;
    logic [15:0] ran_for;
    logic [31:0] elapsed;
    logic        idle;
    logic [15:0] burst_remaining;
    logic [31:0] waited;
  } out_item_t;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_LOAD,
    DP_READ_TAKE,
    DP_WRAP,
    DP_SCAN_CHECK,
    DP_RUN,
    DP_UPD_WRITE,
    DP_EMIT
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
  } dp_ctrl_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic ptr_ge_n;
    logic scan_hit;
    logic cnt_last;
  } dp_status_t;

endpackage

/* rtl/rrps_ctrl.sv */
// controller state machine of the round robin process scheduler
`include "round_robin_process_scheduler_defines.svh"

module rrps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          in_op_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rrps_pkg::dp_ctrl_t   ctrl_o,
  input  rrps_pkg::dp_status_t status_i
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_LOAD      = 11'b00000000010,
    S_READ_WAIT = 11'b00000000100,
    S_READ_TAKE = 11'b00000001000,
    S_WRAP      = 11'b00000010000,
    S_SCAN_RD   = 11'b00000100000,
    S_SCAN_CHK  = 11'b00001000000,
    S_RUN       = 11'b00010000000,
    S_UPD_RD    = 11'b00100000000,
    S_UPD_WR    = 11'b01000000000,
    S_EMIT      = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // new transactions only enter from idle
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and command decode
  always_comb begin
    state_d     = state_q;
    ctrl_o.cmd  = rrps_pkg::DP_NOP;
    out_valid_d = out_valid_q & out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.cmd = rrps_pkg::DP_CAPTURE;
          case (in_op_i)
            rrps_pkg::OP_LOAD:     state_d = S_LOAD;
            rrps_pkg::OP_DISPATCH: state_d = S_WRAP;
            rrps_pkg::OP_READ:     state_d = S_READ_WAIT;
            default:               state_d = S_EMIT;
          endcase
        end
      end
      S_LOAD: begin
        ctrl_o.cmd = rrps_pkg::DP_LOAD;
        state_d    = S_EMIT;
      end
      S_READ_WAIT: begin
        state_d = S_READ_TAKE;
      end
      S_READ_TAKE: begin
        ctrl_o.cmd = rrps_pkg::DP_READ_TAKE;
        state_d    = S_EMIT;
      end
      S_WRAP: begin
        if (status_i.ptr_ge_n) begin
          ctrl_o.cmd = rrps_pkg::DP_WRAP;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        ctrl_o.cmd = rrps_pkg::DP_SCAN_CHECK;
        if (status_i.scan_hit) begin
          state_d = S_RUN;
        end else if (status_i.cnt_last) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_RUN: begin
        ctrl_o.cmd = rrps_pkg::DP_RUN;
        state_d    = S_UPD_RD;
      end
      S_UPD_RD: begin
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        ctrl_o.cmd = rrps_pkg::DP_UPD_WRITE;
        if (status_i.cnt_last) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_UPD_RD;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.cmd  = rrps_pkg::DP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // an accepted transaction always leaves idle
  `RRPS_ASSERT(a_accept_leaves_idle, clk_i, rst_ni,
    (state_q == S_IDLE && in_valid_i) |=> (state_q != S_IDLE))

  // a finished result lands in the output register
  `RRPS_ASSERT(a_emit_sets_valid, clk_i, rst_ni,
    (state_q == S_EMIT && (!out_valid_q || !out_stall_i)) |=> out_valid_q)

  // scan and update pointer stays inside the active entries
  `RRPS_ASSERT(a_ptr_in_range, clk_i, rst_ni,
    (state_q == S_SCAN_CHK || state_q == S_UPD_WR) |-> !status_i.ptr_ge_n)

endmodule

/* rtl/rrps_datapath.sv */
// datapath of the round robin process scheduler: tables, registers, scan pointer
module rrps_datapath #(
  parameter int unsigned NUM_PROCS  = 16,
  parameter int unsigned BURST_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rrps_pkg::in_item_t                  in_data_i,
  input  logic                                cfg_we_i,
  input  logic [rrps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rrps_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  rrps_pkg::dp_ctrl_t                  ctrl_i,
  output rrps_pkg::dp_status_t                status_o,
  output rrps_pkg::out_item_t                 out_data_o
);

  localparam int unsigned IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int unsigned CW = ((IW > 4) ? IW : 4) + 1;
  localparam int unsigned MW = (BURST_BITS > 16) ? BURST_BITS : 16;

  // configuration registers
  logic [4:0]  active_q;
  logic [15:0] quantum_q;
  logic        policy_q;

  // control state
  logic [NUM_PROCS-1:0] vld_q, vld_d;
  logic                 last_valid_q, last_valid_d;
  logic [IW-1:0]        last_q, last_d;
  logic [31:0]          elapsed_q, elapsed_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        cnt_q, cnt_d;

  // captured transaction and working values
  logic                  tbl_q, tbl_d;
  logic [BURST_BITS-1:0] bst_q, bst_d;
  logic [BURST_BITS-1:0] run_q, run_d;
  rrps_pkg::out_item_t   res_q, res_d;
  rrps_pkg::out_item_t   out_q, out_d;

  // table memories
  logic [BURST_BITS-1:0] burst_mem [NUM_PROCS];
  logic [31:0]           wait_mem  [NUM_PROCS];
  logic [BURST_BITS-1:0] brd_q;
  logic [31:0]           wrd_q;
  logic                  vrd_q;
  logic                  bwe, wwe;
  logic [BURST_BITS-1:0] bwdata;
  logic [31:0]           wwdata;
  logic [IW-1:0]         maddr;

  // derived values
  logic [CW-1:0]         act_ext, n_eff, ptr_inc;
  logic [CW-1:0]         in_entry_ext;
  logic                  in_tbl;
  logic [BURST_BITS-1:0] burst_cur;
  logic [31:0]           wait_cur;
  logic [15:0]           q_eff;
  logic [MW-1:0]         burst_ext, q_ext;
  logic [BURST_BITS-1:0] run_calc;
  logic [32:0]           elapsed_sum, wait_sum;
  logic [31:0]           elapsed_sat, wait_sat;

  assign maddr = ptr_q[IW-1:0];

  // effective active count, clamped to 1..NUM_PROCS
  assign act_ext = CW'(active_q);
  always_comb begin
    if (act_ext == '0) begin
      n_eff = CW'(1);
    end else if (act_ext > CW'(NUM_PROCS)) begin
      n_eff = CW'(NUM_PROCS);
    end else begin
      n_eff = act_ext;
    end
  end

  // entry of the incoming transaction inside the table
  assign in_entry_ext = CW'(in_data_i.entry);
  assign in_tbl       = (in_entry_ext < CW'(NUM_PROCS));

  // entry read back, never written entries read as zero
  assign burst_cur = vrd_q ? brd_q : '0;
  assign wait_cur  = vrd_q ? wrd_q : '0;

  // slice length: burst capped at quantum in round robin
  assign q_eff     = (quantum_q == '0) ? 16'd1 : quantum_q;
  assign burst_ext = MW'(burst_cur);
  assign q_ext     = MW'(q_eff);
  assign run_calc  = (policy_q == rrps_pkg::POLICY_RR && burst_ext > q_ext)
                     ? BURST_BITS'(q_ext) : burst_cur;

  // saturating adders for elapsed and wait
  assign elapsed_sum = {1'b0, elapsed_q} + 33'(run_q);
  assign elapsed_sat = elapsed_sum[32] ? '1 : elapsed_sum[31:0];
  assign wait_sum    = {1'b0, wait_cur} + 33'(run_q);
  assign wait_sat    = wait_sum[32] ? '1 : wait_sum[31:0];

  // pointer step with wrap at the active count
  assign ptr_inc = (ptr_q + CW'(1) == n_eff) ? '0 : ptr_q + CW'(1);

  // status for the controller
  assign status_o.ptr_ge_n = (ptr_q >= n_eff);
  assign status_o.scan_hit = (burst_cur != '0);
  assign status_o.cnt_last = (cnt_q == n_eff - CW'(1));

  assign out_data_o = out_q;

  // command execution
  always_comb begin
    vld_d        = vld_q;
    last_valid_d = last_valid_q;
    last_d       = last_q;
    elapsed_d    = elapsed_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    tbl_d        = tbl_q;
    bst_d        = bst_q;
    run_d        = run_q;
    res_d        = res_q;
    out_d        = out_q;
    bwe          = 1'b0;
    wwe          = 1'b0;
    bwdata       = bst_q;
    wwdata       = '0;
    case (ctrl_i.cmd)
      rrps_pkg::DP_CAPTURE: begin
        tbl_d = in_tbl;
        bst_d = BURST_BITS'(in_data_i.burst);
        cnt_d = '0;
        res_d = '0;
        case (in_data_i.op)
          rrps_pkg::OP_LOAD: begin
            res_d.served  = in_data_i.entry;
            res_d.elapsed = in_tbl ? 32'd0 : elapsed_q;
            ptr_d         = in_entry_ext;
          end
          rrps_pkg::OP_DISPATCH: begin
            res_d.elapsed = elapsed_q;
            if (policy_q == rrps_pkg::POLICY_RR && last_valid_q) begin
              ptr_d = CW'(last_q) + CW'(1);
            end else begin
              ptr_d = '0;
            end
          end
          rrps_pkg::OP_READ: begin
            res_d.served  = in_data_i.entry;
            res_d.elapsed = elapsed_q;
            ptr_d         = in_entry_ext;
          end
          default: begin
            ptr_d = '0;
          end
        endcase
      end
      rrps_pkg::DP_LOAD: begin
        if (tbl_q) begin
          bwe          = 1'b1;
          bwdata       = bst_q;
          wwe          = 1'b1;
          wwdata       = '0;
          vld_d[maddr] = 1'b1;
          last_valid_d = 1'b0;
          last_d       = '0;
          elapsed_d    = '0;
        end
      end
      rrps_pkg::DP_READ_TAKE: begin
        if (tbl_q) begin
          res_d.burst_remaining = 16'(burst_cur);
          res_d.waited          = wait_cur;
        end
      end
      rrps_pkg::DP_WRAP: begin
        ptr_d = ptr_q - n_eff;
      end
      rrps_pkg::DP_SCAN_CHECK: begin
        if (burst_cur != '0) begin
          run_d = run_calc;
        end else if (cnt_q != n_eff - CW'(1)) begin
          ptr_d = ptr_inc;
          cnt_d = cnt_q + CW'(1);
        end else begin
          res_d.idle = 1'b1;
        end
      end
      rrps_pkg::DP_RUN: begin
        bwe           = 1'b1;
        bwdata        = burst_cur - run_q;
        last_valid_d  = 1'b1;
        last_d        = maddr;
        elapsed_d     = elapsed_sat;
        res_d.served  = 4'(ptr_q);
        res_d.ran_for = 16'(run_q);
        res_d.elapsed = elapsed_sat;
        ptr_d         = '0;
        cnt_d         = '0;
      end
      rrps_pkg::DP_UPD_WRITE: begin
        if (maddr != last_q && burst_cur != '0) begin
          wwe    = 1'b1;
          wwdata = wait_sat;
        end
        if (cnt_q != n_eff - CW'(1)) begin
          ptr_d = ptr_inc;
          cnt_d = cnt_q + CW'(1);
        end
      end
      rrps_pkg::DP_EMIT: begin
        out_d = res_q;
      end
      default: begin
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 5'd16;
      quantum_q <= 16'd4;
      policy_q  <= rrps_pkg::POLICY_RR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rrps_pkg::REG_ACTIVE_COUNT: active_q  <= cfg_data_i[4:0];
        rrps_pkg::REG_QUANTUM:      quantum_q <= cfg_data_i[15:0];
        rrps_pkg::REG_POLICY:       policy_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // scheduler control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      last_valid_q <= 1'b0;
      last_q       <= '0;
      elapsed_q    <= '0;
      ptr_q        <= '0;
      cnt_q        <= '0;
    end else begin
      vld_q        <= vld_d;
      last_valid_q <= last_valid_d;
      last_q       <= last_d;
      elapsed_q    <= elapsed_d;
      ptr_q        <= ptr_d;
      cnt_q        <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tbl_q <= tbl_d;
    bst_q <= bst_d;
    run_q <= run_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // burst table, registered read
  always_ff @(posedge clk_i) begin
    if (bwe) begin
      burst_mem[maddr] <= bwdata;
    end
    brd_q <= burst_mem[maddr];
    vrd_q <= vld_q[maddr];
  end

  // wait table, registered read
  always_ff @(posedge clk_i) begin
    if (wwe) begin
      wait_mem[maddr] <= wwdata;
    end
    wrd_q <= wait_mem[maddr];
  end

endmodule

/* rtl/round_robin_process_scheduler.sv */
// Round robin / first come first served process scheduler. One transaction in
// gives one transaction out, through an output register, so a finished result
// may wait while the next transaction is taken. Transactions are handled one at
// a time and the block takes the next one once it is back in idle. A dispatch
// walks the entry tables one entry at a time through the single port of each
// table memory: it first subtracts the active count from the round robin start
// while that start lies outside the active range, then scans until an entry
// with burst left is found or every active entry has been seen, and after a
// hit updates the waits of all active entries in a second pass. Any transaction
// also waits before its result is emitted while the previous result is still
// held by the receiver. Entries never loaded read as zero through per-entry
// valid bits, so no clearing pass is needed after reset. Configuration writes
// are taken at any time but must only be issued while the block is idle.
module round_robin_process_scheduler #(
  parameter int unsigned NUM_PROCS  = 16,
  parameter int unsigned BURST_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rrps_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rrps_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [rrps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rrps_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rrps_pkg::dp_ctrl_t   ctrl;
  rrps_pkg::dp_status_t status;

  // sequencing of each transaction
  rrps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_op_i     (in_data_i.op),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl),
    .status_i    (status)
  );

  // tables, configuration and result registers
  rrps_datapath #(
    .NUM_PROCS  (NUM_PROCS),
    .BURST_BITS (BURST_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

/* dv/tb_round_robin_process_scheduler.sv */
// testbench for the round robin process scheduler: directed and random transactions with scoreboard
`timescale 1ns / 100ps

module tb_round_robin_process_scheduler;

  localparam int unsigned NUM_ENTRIES    = 16;
  localparam int unsigned TARGET_ITEMS   = 1900;
  localparam int unsigned IDLE_PCT       = 28;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned TAIL_CYCLES    = 120;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  // expected result store and scheduler predictor
  class sched_scoreboard;
    logic [15:0] burst_rem [NUM_ENTRIES];
    logic [31:0] wait_total [NUM_ENTRIES];
    bit          last_valid;
    int unsigned last_idx;
    logic [31:0] elapsed_total;
    logic [4:0]  active_count;
    logic [15:0] quantum;
    logic        policy;
    rrps_pkg::out_item_t pending_results [$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        burst_rem[i]  = '0;
        wait_total[i] = '0;
      end
      last_valid    = 1'b0;
      last_idx      = 0;
      elapsed_total = '0;
      active_count  = 5'd16;
      quantum       = 16'd4;
      policy        = rrps_pkg::POLICY_RR;
      mismatches    = 0;
      results_seen  = 0;
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function void set_register(logic [rrps_pkg::CFG_IDX_W-1:0] idx,
                               logic [rrps_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        rrps_pkg::REG_ACTIVE_COUNT: active_count = value[4:0];
        rrps_pkg::REG_QUANTUM:      quantum      = value;
        rrps_pkg::REG_POLICY:       policy       = value[0];
        default: ;
      endcase
    endfunction

    // one transaction in, one result out
    function rrps_pkg::out_item_t schedule_item(rrps_pkg::in_item_t item);
      rrps_pkg::out_item_t res;
      int unsigned n, start, idx, pick, i;
      logic [15:0] run, q;
      bit          found;
      res = '0;
      case (item.op)
        rrps_pkg::OP_LOAD: begin
          burst_rem[item.entry]  = item.burst;
          wait_total[item.entry] = '0;
          last_valid    = 1'b0;
          last_idx      = 0;
          elapsed_total = '0;
          res.served    = item.entry;
        end
        rrps_pkg::OP_DISPATCH: begin
          n = (active_count == 0) ? 1 :
              (active_count > NUM_ENTRIES) ? NUM_ENTRIES : active_count;
          start = (policy == rrps_pkg::POLICY_RR && last_valid) ? (last_idx + 1) % n : 0;
          found = 1'b0;
          pick  = 0;
          // scan from the one after the last served in round robin, else from entry zero
          for (i = 0; i < n; i++) begin
            idx = (start + i) % n;
            if (!found && burst_rem[idx] != 0) begin
              found = 1'b1;
              pick  = idx;
            end
          end
          if (!found) begin
            res.elapsed = elapsed_total;
            res.idle    = 1'b1;
          end else begin
            run = burst_rem[pick];
            q   = (quantum == 0) ? 16'd1 : quantum;
            if (policy == rrps_pkg::POLICY_RR && run > q) run = q;
            burst_rem[pick] = burst_rem[pick] - run;
            // everyone else still waiting accrues the slice
            for (i = 0; i < n; i++) begin
              if (i != pick && burst_rem[i] != 0)
                wait_total[i] = sat_add(wait_total[i], {16'd0, run});
            end
            last_valid    = 1'b1;
            last_idx      = pick;
            elapsed_total = sat_add(elapsed_total, {16'd0, run});
            res.served    = 4'(pick);
            res.ran_for   = run;
            res.elapsed   = elapsed_total;
          end
        end
        rrps_pkg::OP_READ: begin
          res.served          = item.entry;
          res.elapsed         = elapsed_total;
          res.burst_remaining = burst_rem[item.entry];
          res.waited          = wait_total[item.entry];
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_input(rrps_pkg::in_item_t item);
      pending_results.push_back(schedule_item(item));
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void check_result(rrps_pkg::out_item_t got);
      rrps_pkg::out_item_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: served=%0d ran_for=%0d",
                   results_seen, got.served, got.ran_for);
        return;
      end
      want = pending_results.pop_front();
      if (got.served !== want.served || got.ran_for !== want.ran_for ||
          got.elapsed !== want.elapsed || got.idle !== want.idle ||
          got.burst_remaining !== want.burst_remaining || got.waited !== want.waited) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch: expected served=%0d ran_for=%0d elapsed=%0d idle=%0d burst=%0d waited=%0d",
                   results_seen, want.served, want.ran_for, want.elapsed, want.idle,
                   want.burst_remaining, want.waited);
          $display("result %0d mismatch: got served=%0d ran_for=%0d elapsed=%0d idle=%0d burst=%0d waited=%0d",
                   results_seen, got.served, got.ran_for, got.elapsed, got.idle,
                   got.burst_remaining, got.waited);
        end
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n    = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  rrps_pkg::in_item_t              in_data  = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  rrps_pkg::out_item_t             out_data;
  logic                            cfg_we   = 1'b0;
  logic [rrps_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [rrps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  sched_scoreboard sb;
  bit              gaps_on      = 1'b1;
  bit              hold_trigger = 1'b0;
  bit              hold_started = 1'b0;
  int unsigned     hold_left    = 0;
  int unsigned     items_sent   = 0;
  int unsigned     quiet_cycles = 0;

  round_robin_process_scheduler u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check accepted transactions, then pick next stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (hold_trigger && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("round_robin_process_scheduler test failed");
        $finish;
      end
    end
  end

  // offer one transaction and wait until it is taken
  task automatic push_item(input logic [1:0] op, input logic [3:0] entry,
                           input logic [15:0] burst);
    rrps_pkg::in_item_t item;
    item.op    = op;
    item.entry = entry;
    item.burst = burst;
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(item);
    items_sent++;
  endtask

  // drop valid and let every outstanding result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rrps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rrps_pkg::CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  task automatic set_config(input logic [4:0] act, input logic [15:0] quant, input logic pol);
    wait_idle();
    write_reg(rrps_pkg::REG_ACTIVE_COUNT, {11'd0, act});
    write_reg(rrps_pkg::REG_QUANTUM, quant);
    write_reg(rrps_pkg::REG_POLICY, {15'd0, pol});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_burst();
    case ($urandom_range(19))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(65535));
      default: return 16'($urandom_range(40, 1));
    endcase
  endfunction

  function automatic logic [3:0] pick_entry(input int unsigned n_eff);
    if ($urandom_range(9) < 8) return 4'($urandom_range(n_eff - 1));
    return 4'($urandom_range(15));
  endfunction

  task automatic run_directed();
    // reset config: idle dispatch, empty read, unused op, extremes of load
    push_item(rrps_pkg::OP_DISPATCH, 4'd0, 16'd0);
    push_item(rrps_pkg::OP_READ, 4'd0, 16'd0);
    push_item(OP_UNUSED, 4'd15, 16'hFFFF);
    push_item(rrps_pkg::OP_LOAD, 4'd15, 16'hFFFF);
    push_item(rrps_pkg::OP_LOAD, 4'd0, 16'd0);
    push_item(rrps_pkg::OP_LOAD, 4'd3, 16'd5);
    push_item(rrps_pkg::OP_DISPATCH, 4'd0, 16'd0);
    push_item(rrps_pkg::OP_DISPATCH, 4'd15, 16'hFFFF);
    push_item(rrps_pkg::OP_READ, 4'd15, 16'd0);
    push_item(rrps_pkg::OP_READ, 4'd3, 16'd0);
    // zero quantum and an active count above the table size
    set_config(5'd31, 16'd0, rrps_pkg::POLICY_RR);
    push_item(rrps_pkg::OP_DISPATCH, 4'd0, 16'd0);
    push_item(rrps_pkg::OP_DISPATCH, 4'd0, 16'd0);
    push_item(rrps_pkg::OP_READ, 4'd3, 16'd0);
    // zero active count, largest quantum
    set_config(5'd0, 16'hFFFF, rrps_pkg::POLICY_RR);
    push_item(rrps_pkg::OP_LOAD, 4'd0, 16'd7);
    push_item(rrps_pkg::OP_DISPATCH, 4'd0, 16'd0);
    push_item(rrps_pkg::OP_DISPATCH, 4'd0, 16'd0);
    push_item(rrps_pkg::OP_READ, 4'd15, 16'd0);
    // fcfs runs to completion
    set_config(5'd16, 16'd4, rrps_pkg::POLICY_FCFS);
    push_item(rrps_pkg::OP_DISPATCH, 4'd0, 16'd0);
    push_item(rrps_pkg::OP_DISPATCH, 4'd0, 16'd0);
    push_item(rrps_pkg::OP_READ, 4'd15, 16'd0);
    push_item(rrps_pkg::OP_LOAD, 4'd2, 16'hFFFF);
    push_item(rrps_pkg::OP_LOAD, 4'd1, 16'd3);
    push_item(rrps_pkg::OP_DISPATCH, 4'd0, 16'd0);
    push_item(rrps_pkg::OP_DISPATCH, 4'd0, 16'd0);
  endtask

  // one workload: new settings, a batch of loads, then mostly dispatches
  task automatic run_random_phase(input int unsigned phase);
    logic [4:0]  act;
    logic [15:0] quant;
    logic        pol;
    int unsigned n_eff, loads, body, sel;
    case ($urandom_range(9))
      0:       act = 5'd16;
      1:       act = 5'd1;
      2:       act = 5'($urandom_range(31));
      default: act = 5'($urandom_range(16, 1));
    endcase
    case ($urandom_range(9))
      0:       quant = 16'hFFFF;
      1:       quant = 16'd0;
      2:       quant = 16'($urandom_range(65535));
      default: quant = 16'($urandom_range(12, 1));
    endcase
    pol = 1'($urandom_range(1));
    set_config(act, quant, pol);
    n_eff = (act == 0) ? 1 : (act > NUM_ENTRIES) ? NUM_ENTRIES : act;
    gaps_on = !(phase >= 6 && phase < 12);
    if (phase == 3) hold_trigger = 1'b1;
    loads = $urandom_range(n_eff, 1);
    repeat (loads) push_item(rrps_pkg::OP_LOAD, pick_entry(n_eff), rand_burst());
    body = $urandom_range(50, 15);
    repeat (body) begin
      sel = $urandom_range(99);
      if (sel < 62)
        push_item(rrps_pkg::OP_DISPATCH, 4'($urandom_range(15)), 16'($urandom_range(65535)));
      else if (sel < 80)
        push_item(rrps_pkg::OP_READ, 4'($urandom_range(15)), 16'($urandom_range(65535)));
      else if (sel < 94)
        push_item(rrps_pkg::OP_LOAD, pick_entry(n_eff), rand_burst());
      else
        push_item(OP_UNUSED, 4'($urandom_range(15)), 16'($urandom_range(65535)));
    end
  endtask

  // main sequence
  initial begin
    int unsigned phase;
    sb    = new();
    phase = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    while (items_sent < TARGET_ITEMS) begin
      run_random_phase(phase);
      phase++;
    end
    gaps_on = 1'b1;
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("round_robin_process_scheduler test passed");
    end else begin
      $display("round_robin_process_scheduler test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/rrps_pkg.sv
rtl/rrps_ctrl.sv
rtl/rrps_datapath.sv
rtl/round_robin_process_scheduler.sv
dv/tb_round_robin_process_scheduler.sv
